FILE: design/pft_pkg.sv
`timescale 1ns / 1ps

package pft_pkg;

  localparam int INDEX_DEPTH       = 4096;
  localparam int MAX_FACE_VERTICES = 64;

  localparam int ADDR_W  = $clog2(INDEX_DEPTH);
  localparam int CNT_W   = $clog2(INDEX_DEPTH + 1);
  localparam int POS_W   = $clog2(MAX_FACE_VERTICES);
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 32;
  localparam int FACE_W  = 16;
  localparam int SUM_W   = ((CNT_W > FACE_W) ? CNT_W : FACE_W) + 1;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FACE_W-1:0] face_t;

  localparam cmd_t CMD_APPEND   = 2'd0;
  localparam cmd_t CMD_FACE     = 2'd1;
  localparam cmd_t CMD_NEW_MESH = 2'd2;

endpackage

FILE: design/pft_in_if.sv
`timescale 1ns / 1ps

interface pft_in_if;
  import pft_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  idx_t  index_value;
  face_t face_count;

  modport source (output valid, output command, output index_value, output face_count,
                  input ready);
  modport sink   (input valid, input command, input index_value, input face_count,
                  output ready);
endinterface

FILE: design/pft_out_if.sv
`timescale 1ns / 1ps

interface pft_out_if;
  import pft_pkg::*;

  logic valid;
  logic ready;
  idx_t vertex_a;
  idx_t vertex_b;
  idx_t vertex_c;
  logic triangle_present;
  logic mesh_valid;
  logic last;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  output triangle_present, output mesh_valid, output last,
                  input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input triangle_present, input mesh_valid, input last,
                  output ready);
endinterface

FILE: design/polygon_fan_triangulator_unit.sv
`timescale 1ns / 1ps
// Fan triangulator for one mesh at a time.
// in_ch carries commands: append a vertex index to the index memory,
// process one face vertex count, or start a new mesh. out_ch carries
// triangles (apex, b, c) with last set on the final triangle of a face, or
// a single status item with mesh_valid low once the mesh has gone invalid.
// Appends and new-mesh commands produce no item.
// A valid face of n vertices holds in_ch.ready low until its last triangle
// is loaded: the sequencer fetches the apex and the second vertex from the
// single-port-read index memory, then one triangle per cycle follows while
// out_ch does not stall, one memory read each, n-2 triangles in all; the
// first triangle reaches out_ch after the APEX, SECOND and TRI states. An
// invalid face yields one status item.
// A single output register parts the channels; when out_ch stalls the
// sequencer holds its memory address and rereads the same entry, and
// resumes without loss once the register drains.
// Reset clears the counters, sets mesh validity and empties the output;
// index memory contents are left as they are and read only after written.
module polygon_fan_triangulator_unit (
  input  logic             clk,
  input  logic             rst_n,
  pft_in_if.sink           in_ch,
  pft_out_if.source        out_ch
);
  import pft_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APEX   = 3'd1;
  localparam logic [2:0] ST_SECOND = 3'd2;
  localparam logic [2:0] ST_TRI    = 3'd3;
  localparam logic [2:0] ST_STATUS = 3'd4;

  idx_t mem [INDEX_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [CNT_W-1:0] offset_r, offset_nxt;
  logic             valid_flag_r, valid_flag_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] last_pos_r, last_pos_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  idx_t             rdata_r;
  idx_t             apex_r, apex_nxt;
  idx_t             prev_r, prev_nxt;

  logic             out_valid_r, out_valid_nxt;
  idx_t             out_a_r, out_a_nxt;
  idx_t             out_b_r, out_b_nxt;
  idx_t             out_c_r, out_c_nxt;
  logic             out_tri_r, out_tri_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             can_load;
  logic             wr_en;
  logic [SUM_W-1:0] end_sum;
  logic             face_ok;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_load    = !out_valid_r || out_ch.ready;

  assign end_sum = SUM_W'(offset_r) + SUM_W'(in_ch.face_count);
  assign face_ok = valid_flag_r && (in_ch.face_count >= FACE_W'(3)) &&
                   (in_ch.face_count <= FACE_W'(MAX_FACE_VERTICES)) &&
                   (end_sum <= SUM_W'(stored_r));

  assign wr_en = accept && (in_ch.command == CMD_APPEND) &&
                 (stored_r < CNT_W'(INDEX_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[stored_r[ADDR_W-1:0]] <= in_ch.index_value;
    end
    rdata_r <= mem[rd_addr_nxt];
  end

  always_comb begin
    state_nxt      = state_r;
    stored_nxt     = stored_r;
    offset_nxt     = offset_r;
    valid_flag_nxt = valid_flag_r;
    pos_nxt        = pos_r;
    last_pos_nxt   = last_pos_r;
    rd_addr_nxt    = rd_addr_r;
    apex_nxt       = apex_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_a_nxt      = out_a_r;
    out_b_nxt      = out_b_r;
    out_c_nxt      = out_c_r;
    out_tri_nxt    = out_tri_r;
    out_ok_nxt     = out_ok_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_APPEND: begin
              if (wr_en) begin
                stored_nxt = stored_r + 1'b1;
              end
            end
            CMD_FACE: begin
              valid_flag_nxt = face_ok;
              if (end_sum > SUM_W'(INDEX_DEPTH)) begin
                offset_nxt = CNT_W'(INDEX_DEPTH);
              end else begin
                offset_nxt = end_sum[CNT_W-1:0];
              end
              last_pos_nxt = POS_W'(in_ch.face_count - FACE_W'(1));
              rd_addr_nxt  = offset_r[ADDR_W-1:0];
              state_nxt    = face_ok ? ST_APEX : ST_STATUS;
            end
            CMD_NEW_MESH: begin
              stored_nxt     = '0;
              offset_nxt     = '0;
              valid_flag_nxt = 1'b1;
              pos_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_APEX: begin
        apex_nxt    = rdata_r;
        rd_addr_nxt = rd_addr_r + 1'b1;
        state_nxt   = ST_SECOND;
      end
      ST_SECOND: begin
        prev_nxt    = rdata_r;
        rd_addr_nxt = rd_addr_r + 1'b1;
        pos_nxt     = POS_W'(2);
        state_nxt   = ST_TRI;
      end
      ST_TRI: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = apex_r;
          out_b_nxt     = prev_r;
          out_c_nxt     = rdata_r;
          out_tri_nxt   = 1'b1;
          out_ok_nxt    = 1'b1;
          out_last_nxt  = (pos_r == last_pos_r);
          prev_nxt      = rdata_r;
          if (pos_r == last_pos_r) begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt     = pos_r + 1'b1;
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
      end
      ST_STATUS: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = '0;
          out_b_nxt     = '0;
          out_c_nxt     = '0;
          out_tri_nxt   = 1'b0;
          out_ok_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stored_r     <= '0;
      offset_r     <= '0;
      valid_flag_r <= 1'b1;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stored_r     <= stored_nxt;
      offset_r     <= offset_nxt;
      valid_flag_r <= valid_flag_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_pos_r <= last_pos_nxt;
    rd_addr_r  <= rd_addr_nxt;
    apex_r     <= apex_nxt;
    prev_r     <= prev_nxt;
    out_a_r    <= out_a_nxt;
    out_b_r    <= out_b_nxt;
    out_c_r    <= out_c_nxt;
    out_tri_r  <= out_tri_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.vertex_a         = out_a_r;
  assign out_ch.vertex_b         = out_b_r;
  assign out_ch.vertex_c         = out_c_r;
  assign out_ch.triangle_present = out_tri_r;
  assign out_ch.mesh_valid       = out_ok_r;
  assign out_ch.last             = out_last_r;

  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tri_r) |-> (!out_ok_r && out_last_r))
    else $error("status item without invalid mark or last");

  a_face_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.command == CMD_FACE)) |=> !in_ch.ready)
    else $error("input ready right after a face item");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRI) |-> (CNT_W'(rd_addr_r) < stored_r))
    else $error("fan read beyond stored indices");

  a_tri_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APEX || state_r == ST_SECOND || state_r == ST_TRI) |-> valid_flag_r)
    else $error("triangle fetch while mesh invalid");

  a_stall_holds_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRI && !can_load) |=> $stable(rd_addr_r))
    else $error("read address moved during output stall");

endmodule
